// ===== hw/rtl/bsfe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsfe_pkg
// Shared types and constants of the byte stuffing frame encoder.
// ----------------------------------------------------------------------------
package bsfe_pkg;

   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned CSR_IDX_W = 3;

   localparam logic [CSR_IDX_W-1:0] REG_FLAG_BYTE      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ESCAPE_BYTE    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_FLAG_SUBST     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_ESCAPE_SUBST   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_ADDRESS_BYTE   = 3'd4;

   localparam logic [BYTE_W-1:0] RST_FLAG_BYTE    = 8'h7E;
   localparam logic [BYTE_W-1:0] RST_ESCAPE_BYTE  = 8'h7D;
   localparam logic [BYTE_W-1:0] RST_FLAG_SUBST   = 8'h5E;
   localparam logic [BYTE_W-1:0] RST_ESCAPE_SUBST = 8'h5D;
   localparam logic [BYTE_W-1:0] RST_ADDRESS_BYTE = 8'h03;

   localparam logic [BYTE_W-1:0] CTRL_SEQ0 = 8'h00;
   localparam logic [BYTE_W-1:0] CTRL_SEQ1 = 8'h02;

   typedef struct packed {
      logic [BYTE_W-1:0] flag_byte;
      logic [BYTE_W-1:0] escape_byte;
      logic [BYTE_W-1:0] flag_substitute;
      logic [BYTE_W-1:0] escape_substitute;
      logic [BYTE_W-1:0] address_byte;
   } bsfe_cfg_type;

   typedef enum logic [1:0] {
      KIND_PLAIN,
      KIND_FLAG,
      KIND_ESC
   } bsfe_kind_type;

   typedef enum logic [3:0] {
      PH_START,
      PH_HDR_FLAG,
      PH_HDR_ADDR,
      PH_HDR_CTRL,
      PH_HDR_CHECK,
      PH_DATA0,
      PH_DATA1,
      PH_CHK0,
      PH_CHK1,
      PH_CLOSE
   } bsfe_phase_type;

   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic [BYTE_W-1:0] chk;
      bsfe_kind_type     data_kind;
      bsfe_kind_type     chk_kind;
      logic              is_first;
      logic              is_last;
      logic              seq;
   } bsfe_entry_type;

   typedef struct packed {
      logic           valid;
      bsfe_entry_type entry;
   } bsfe_slot_type;

   function automatic bsfe_kind_type classify(input logic [BYTE_W-1:0] b,
                                              input bsfe_cfg_type cfg);
      bsfe_kind_type k;
      if (b == cfg.flag_byte) begin
         k = KIND_FLAG;
      end else if (b == cfg.escape_byte) begin
         k = KIND_ESC;
      end else begin
         k = KIND_PLAIN;
      end
      return k;
   endfunction

endpackage

// ===== hw/rtl/bsfe_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsfe channel interfaces
// Valid/ready channels for input items, line bytes and register writes.
// ----------------------------------------------------------------------------
interface bsfe_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] payload_byte;
   logic       first_byte;
   logic       final_byte;
   logic       sequence_bit;

   modport source (output valid, payload_byte, first_byte, final_byte, sequence_bit,
                   input ready);
   modport sink   (input valid, payload_byte, first_byte, final_byte, sequence_bit,
                   output ready);
endinterface

interface bsfe_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] line_byte;
   logic       run_end;
   logic       frame_done;

   modport source (output valid, line_byte, run_end, frame_done, input ready);
   modport sink   (input valid, line_byte, run_end, frame_done, output ready);
endinterface

interface bsfe_csr_if;
   logic       valid;
   logic       ready;
   logic [2:0] index;
   logic [7:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/bsfe_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsfe_front
// Accepts payload items, keeps the running XOR check and classifies bytes.
// ----------------------------------------------------------------------------
module bsfe_front (
   input  logic                  clock,
   input  logic                  reset,
   bsfe_req_if.sink              req_if,
   input  bsfe_pkg::bsfe_cfg_type cfg,
   input  logic                  queue_full,
   output bsfe_pkg::bsfe_slot_type push
);

   logic [7:0] check_ff;
   logic [7:0] check_in;
   logic [7:0] check_next;
   logic       accept;

   assign req_if.ready = !queue_full;
   assign accept       = req_if.valid && !queue_full;

   always_comb begin
      check_next = (req_if.first_byte ? 8'h00 : check_ff) ^ req_if.payload_byte;
      check_in   = check_ff;
      if (accept) begin
         check_in = req_if.final_byte ? 8'h00 : check_next;
      end
      push.valid           = accept;
      push.entry.data      = req_if.payload_byte;
      push.entry.chk       = check_next;
      push.entry.data_kind = bsfe_pkg::classify(req_if.payload_byte, cfg);
      push.entry.chk_kind  = bsfe_pkg::classify(check_next, cfg);
      push.entry.is_first  = req_if.first_byte;
      push.entry.is_last   = req_if.final_byte;
      push.entry.seq       = req_if.sequence_bit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         check_ff <= 8'h00;
      end else begin
         check_ff <= check_in;
      end
   end

endmodule

// ===== hw/rtl/bsfe_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsfe_queue
// Short queue of classified items between front and back.
// ----------------------------------------------------------------------------
module bsfe_queue #(
   parameter int unsigned DEPTH = 4
) (
   input  logic                    clock,
   input  logic                    reset,
   input  bsfe_pkg::bsfe_slot_type push,
   input  logic                    pop,
   output logic                    full,
   output bsfe_pkg::bsfe_slot_type head
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

   bsfe_pkg::bsfe_entry_type mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full       = (count_ff == DEPTH_CNT);
   assign head.valid = (count_ff != '0);
   assign head.entry = mem_ff[rd_ptr_ff];
   assign do_push    = push.valid && !full;
   assign do_pop     = pop && head.valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push.entry;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_CNT)
      else $error("queue count beyond depth");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> head.valid)
      else $error("pop from empty queue");

endmodule

// ===== hw/rtl/bsfe_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsfe_back
// Expands the head item into header, stuffed bytes, check and closing flag.
// ----------------------------------------------------------------------------
module bsfe_back (
   input  logic                    clock,
   input  logic                    reset,
   input  bsfe_pkg::bsfe_cfg_type  cfg,
   input  bsfe_pkg::bsfe_slot_type head,
   output logic                    pop,
   bsfe_rsp_if.source              rsp_if
);

   bsfe_pkg::bsfe_phase_type state_ff, state_in;
   bsfe_pkg::bsfe_phase_type cur;
   bsfe_pkg::bsfe_phase_type nxt;
   bsfe_pkg::bsfe_entry_type e;

   logic       out_valid_ff, out_valid_in;
   logic [7:0] line_byte_ff, line_byte_in;
   logic       run_end_ff, run_end_in;
   logic       frame_done_ff, frame_done_in;
   logic       advance;
   logic       done;
   logic [7:0] ctrl;

   assign rsp_if.valid      = out_valid_ff;
   assign rsp_if.line_byte  = line_byte_ff;
   assign rsp_if.run_end    = run_end_ff;
   assign rsp_if.frame_done = frame_done_ff;

   always_comb begin
      e       = head.entry;
      advance = head.valid && (!out_valid_ff || rsp_if.ready);
      ctrl    = e.seq ? bsfe_pkg::CTRL_SEQ1 : bsfe_pkg::CTRL_SEQ0;
      if (state_ff == bsfe_pkg::PH_START) begin
         cur = e.is_first ? bsfe_pkg::PH_HDR_FLAG : bsfe_pkg::PH_DATA0;
      end else begin
         cur = state_ff;
      end

      nxt           = bsfe_pkg::PH_START;
      line_byte_in  = cfg.flag_byte;
      frame_done_in = 1'b0;
      case (cur)
         bsfe_pkg::PH_HDR_FLAG: begin
            line_byte_in = cfg.flag_byte;
            nxt          = bsfe_pkg::PH_HDR_ADDR;
         end
         bsfe_pkg::PH_HDR_ADDR: begin
            line_byte_in = cfg.address_byte;
            nxt          = bsfe_pkg::PH_HDR_CTRL;
         end
         bsfe_pkg::PH_HDR_CTRL: begin
            line_byte_in = ctrl;
            nxt          = bsfe_pkg::PH_HDR_CHECK;
         end
         bsfe_pkg::PH_HDR_CHECK: begin
            line_byte_in = cfg.address_byte ^ ctrl;
            nxt          = bsfe_pkg::PH_DATA0;
         end
         bsfe_pkg::PH_DATA0: begin
            if (e.data_kind == bsfe_pkg::KIND_PLAIN) begin
               line_byte_in = e.data;
               nxt          = e.is_last ? bsfe_pkg::PH_CHK0 : bsfe_pkg::PH_START;
            end else begin
               line_byte_in = cfg.escape_byte;
               nxt          = bsfe_pkg::PH_DATA1;
            end
         end
         bsfe_pkg::PH_DATA1: begin
            line_byte_in = (e.data_kind == bsfe_pkg::KIND_FLAG) ?
                           cfg.flag_substitute : cfg.escape_substitute;
            nxt          = e.is_last ? bsfe_pkg::PH_CHK0 : bsfe_pkg::PH_START;
         end
         bsfe_pkg::PH_CHK0: begin
            if (e.chk_kind == bsfe_pkg::KIND_PLAIN) begin
               line_byte_in = e.chk;
               nxt          = bsfe_pkg::PH_CLOSE;
            end else begin
               line_byte_in = cfg.escape_byte;
               nxt          = bsfe_pkg::PH_CHK1;
            end
         end
         bsfe_pkg::PH_CHK1: begin
            line_byte_in = (e.chk_kind == bsfe_pkg::KIND_FLAG) ?
                           cfg.flag_substitute : cfg.escape_substitute;
            nxt          = bsfe_pkg::PH_CLOSE;
         end
         bsfe_pkg::PH_CLOSE: begin
            line_byte_in  = cfg.flag_byte;
            frame_done_in = 1'b1;
            nxt           = bsfe_pkg::PH_START;
         end
         default: begin
            line_byte_in = cfg.flag_byte;
            nxt          = bsfe_pkg::PH_START;
         end
      endcase

      done       = (nxt == bsfe_pkg::PH_START);
      run_end_in = done;
      pop        = advance && done;
      state_in   = advance ? nxt : state_ff;

      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bsfe_pkg::PH_START;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         line_byte_ff  <= line_byte_in;
         run_end_ff    <= run_end_in;
         frame_done_ff <= frame_done_in;
      end
   end

   a_done_ends_run: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && frame_done_ff) |-> run_end_ff)
      else $error("closing flag without end of run");

   a_busy_has_item: assert property (@(posedge clock) disable iff (reset)
      (state_ff != bsfe_pkg::PH_START) |-> head.valid)
      else $error("expansion in progress with empty queue");

   a_pop_marks_end: assert property (@(posedge clock) disable iff (reset)
      pop |=> (out_valid_ff && run_end_ff))
      else $error("item retired without end of run");

endmodule

// ===== hw/rtl/byte_stuffing_frame_encoder_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_stuffing_frame_encoder_core
// Frames payload bytes with flag, header, stuffing, XOR check and close.
//
//   channel   dir   carries
//   req_if    in    payload_byte, first_byte, final_byte, sequence_bit
//   rsp_if    out   line_byte, run_end, frame_done
//   csr_if    in    index, data (five 8-bit registers)
//
// One line byte leaves per cycle while the line side is ready; an item
// expands to 1 to 9 line bytes (plain byte 1, stuffed byte 2, header 4,
// check 1-2, closing flag 1). The back sequencer's single output register sets the rate.
// Synchronous reset clears queue, check and registers to defaults.
// The front keeps accepting while the queue has room, even when the line
// side stalls; register writes are taken every cycle.
// ----------------------------------------------------------------------------
module byte_stuffing_frame_encoder_core #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   bsfe_req_if.sink   req_if,
   bsfe_rsp_if.source rsp_if,
   bsfe_csr_if.sink   csr_if
);

   bsfe_pkg::bsfe_cfg_type  cfg_ff, cfg_in;
   bsfe_pkg::bsfe_slot_type push;
   bsfe_pkg::bsfe_slot_type head;
   logic                    queue_full;
   logic                    pop;

   assign csr_if.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_if.valid) begin
         case (csr_if.index)
            bsfe_pkg::REG_FLAG_BYTE:    cfg_in.flag_byte         = csr_if.data;
            bsfe_pkg::REG_ESCAPE_BYTE:  cfg_in.escape_byte       = csr_if.data;
            bsfe_pkg::REG_FLAG_SUBST:   cfg_in.flag_substitute   = csr_if.data;
            bsfe_pkg::REG_ESCAPE_SUBST: cfg_in.escape_substitute = csr_if.data;
            bsfe_pkg::REG_ADDRESS_BYTE: cfg_in.address_byte      = csr_if.data;
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.flag_byte         <= bsfe_pkg::RST_FLAG_BYTE;
         cfg_ff.escape_byte       <= bsfe_pkg::RST_ESCAPE_BYTE;
         cfg_ff.flag_substitute   <= bsfe_pkg::RST_FLAG_SUBST;
         cfg_ff.escape_substitute <= bsfe_pkg::RST_ESCAPE_SUBST;
         cfg_ff.address_byte      <= bsfe_pkg::RST_ADDRESS_BYTE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   bsfe_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .cfg        (cfg_ff),
      .queue_full (queue_full),
      .push       (push)
   );

   bsfe_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .full  (queue_full),
      .head  (head)
   );

   bsfe_back u_back (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg_ff),
      .head   (head),
      .pop    (pop),
      .rsp_if (rsp_if)
   );

endmodule
